// ===== rtl/lpfd_pkg.sv =====
// Package for the length-prefixed frame deframer.
// Holds the byte codes, phase and event enums and the beat struct; no dependencies.
`default_nettype none

package lpfd_pkg;

  localparam logic [7:0]  SyncFirst     = 8'hAA;
  localparam logic [7:0]  SyncSecond    = 8'hBB;
  localparam logic [7:0]  TailFirst     = 8'hCC;
  localparam logic [7:0]  TailSecond    = 8'hDD;
  localparam logic [15:0] MaxLenDefault = 16'd4096;

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhSawAa   = 3'd1,
    PhLenHi   = 3'd2,
    PhLenLo   = 3'd3,
    PhPayload = 3'd4,
    PhTail1   = 3'd5,
    PhTail2   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    EvPayload = 2'd0,
    EvAccept  = 2'd1,
    EvBadTail = 2'd2,
    EvOversize = 2'd3
  } event_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

endpackage

`default_nettype wire

// ===== rtl/lpfd_in_reg.sv =====
// Input register of the deframer: holds one received beat until the core takes it.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [7:0]          rx_byte_i,
  input  wire                 take_i,
  output lpfd_pkg::beat_t     beat_o
);
  import lpfd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (accept) begin
      valid_d = 1'b1;
      data_d  = rx_byte_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

`default_nettype wire

// ===== rtl/lpfd_core.sv =====
// Deframer core: per-beat phase machine and the result register.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lpfd_pkg::beat_t     beat_i,
  output logic                take_o,
  input  wire  [15:0]         max_len_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output lpfd_pkg::event_e    event_kind_o,
  output logic [7:0]          payload_byte_o,
  output logic [15:0]         frame_length_o
);
  import lpfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] decl_len_q, decl_len_d;
  logic [15:0] remain_q, remain_d;
  logic        tail_ok_q, tail_ok_d;
  logic        out_valid_q, out_valid_d;
  event_e      kind_q, kind_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [15:0] flen_q, flen_d;

  logic        emit;
  event_e      emit_kind;
  logic [7:0]  emit_byte;
  logic [15:0] emit_len;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] remain_dec;
  phase_e      hunt_ph;

  assign take_o     = beat_i.valid && !(out_valid_q && out_stall_i);
  assign b          = beat_i.data;
  assign len        = {len_hi_q, b};
  assign remain_dec = remain_q - 16'd1;
  assign hunt_ph    = (b == SyncFirst) ? PhSawAa : PhHunt;

  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    decl_len_d = decl_len_q;
    remain_d   = remain_q;
    tail_ok_d  = tail_ok_q;
    emit       = 1'b0;
    emit_kind  = EvPayload;
    emit_byte  = 8'd0;
    emit_len   = 16'd0;
    if (take_o) begin
      case (phase_q)
        PhSawAa: begin
          phase_d = (b == SyncSecond) ? PhLenHi : hunt_ph;
        end
        PhLenHi: begin
          len_hi_d = b;
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          decl_len_d = len;
          if (len > max_len_i) begin
            if (len_hi_q == SyncFirst && b == SyncSecond) begin
              phase_d = PhLenHi;
            end else begin
              phase_d = hunt_ph;
            end
            emit      = 1'b1;
            emit_kind = EvOversize;
            emit_len  = len;
          end else begin
            remain_d = len;
            phase_d  = (len == 16'd0) ? PhTail1 : PhPayload;
          end
        end
        PhPayload: begin
          remain_d = remain_dec;
          if (remain_dec == 16'd0) begin
            phase_d = PhTail1;
          end
          emit      = 1'b1;
          emit_kind = EvPayload;
          emit_byte = b;
        end
        PhTail1: begin
          tail_ok_d = (b == TailFirst);
          phase_d   = PhTail2;
        end
        PhTail2: begin
          phase_d   = PhHunt;
          emit      = 1'b1;
          emit_kind = (tail_ok_q && b == TailSecond) ? EvAccept : EvBadTail;
          emit_len  = decl_len_q;
        end
        default: begin
          phase_d = hunt_ph;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    pbyte_d     = pbyte_q;
    flen_d      = flen_q;
    if (emit) begin
      out_valid_d = 1'b1;
      kind_d      = emit_kind;
      pbyte_d     = emit_byte;
      flen_d      = emit_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      len_hi_q    <= 8'd0;
      decl_len_q  <= 16'd0;
      remain_q    <= 16'd0;
      tail_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_hi_q    <= len_hi_d;
      decl_len_q  <= decl_len_d;
      remain_q    <= remain_d;
      tail_ok_q   <= tail_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    pbyte_q <= pbyte_d;
    flen_q  <= flen_d;
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign payload_byte_o = pbyte_q;
  assign frame_length_o = flen_q;

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer: max-length register and wiring.
// Depends on lpfd_pkg, lpfd_in_reg and lpfd_core.
//
// Deframes AA BB, 16-bit big-endian length, payload, CC DD from a byte stream at one
// beat per clock while out_stall_i does not hold a result. Each byte passes through an
// input register and then the phase machine, which loads the result register. The
// input register takes one more byte while a result waits on out_stall_i, so the block
// stalls only when both registers are full. Each payload byte gives a payload event;
// the second tail byte gives an accepted or bad-tail event, and a length above the
// max-length register gives an oversize event on the low length byte. The max-length
// register resets to 4096 and is written over the cfg channel, which is always ready;
// write it only while the block is idle.
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] frame_length_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i
);
  import lpfd_pkg::*;

  logic [15:0] max_len_q, max_len_d;
  beat_t       beat;
  logic        take;
  event_e      kind;

  assign cfg_ready_o = 1'b1;
  assign max_len_d   = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenDefault;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  lpfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .beat_o     (beat)
  );

  lpfd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .take_o         (take),
    .max_len_i      (max_len_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (kind),
    .payload_byte_o (payload_byte_o),
    .frame_length_o (frame_length_o)
  );

  assign event_kind_o = kind;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register free");

  a_payload_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind == EvPayload) |-> (frame_length_o == 16'd0))
    else $error("payload beat carries a frame length");

  a_event_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind != EvPayload) |-> (payload_byte_o == 8'd0))
    else $error("frame event carries a payload byte");
`endif

endmodule

`default_nettype wire

// ===== dv/length_prefixed_frame_deframer_tb.sv =====
// Self-checking testbench for length_prefixed_frame_deframer: directed and random byte
// streams, with the expected event stream predicted in step with each accepted beat.
// Depends on lpfd_pkg and the length_prefixed_frame_deframer RTL.
module length_prefixed_frame_deframer_tb;
  import lpfd_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned RandomBytes = 620;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  data;
    logic [15:0] length;
  } deframe_event_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  rx_byte_i    = 8'h00;
  logic        out_stall_i  = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic [15:0] cfg_data_i   = 16'h0000;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  event_kind_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] frame_length_o;
  logic        cfg_ready_o;

  deframe_event_t pending_events[$];
  deframe_event_t head_event;

  phase_e      st_phase;
  logic [7:0]  st_len_hi;
  logic [15:0] st_decl_len;
  logic [15:0] st_left;
  logic        st_tail_ok;
  logic [15:0] st_max_len;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned hold_count;
  bit          hold_request;

  length_prefixed_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_length_o(frame_length_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_event(input event_e kind, input logic [7:0] data,
                                     input logic [15:0] length);
    deframe_event_t ev;
    ev.kind   = kind;
    ev.data   = data;
    ev.length = length;
    pending_events.push_back(ev);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0] len;
    case (st_phase)
      PhSawAa: begin
        if (b == SyncSecond) st_phase = PhLenHi;
        else if (b == SyncFirst) st_phase = PhSawAa;
        else st_phase = PhHunt;
      end
      PhLenHi: begin
        st_len_hi = b;
        st_phase  = PhLenLo;
      end
      PhLenLo: begin
        len = {st_len_hi, b};
        st_decl_len = len;
        if (len > st_max_len) begin
          if (st_len_hi == SyncFirst && b == SyncSecond) st_phase = PhLenHi;
          else if (b == SyncFirst) st_phase = PhSawAa;
          else st_phase = PhHunt;
          push_event(EvOversize, 8'h00, len);
        end else begin
          st_left = len;
          if (len == 16'd0) st_phase = PhTail1;
          else st_phase = PhPayload;
        end
      end
      PhPayload: begin
        st_left = st_left - 16'd1;
        if (st_left == 16'd0) st_phase = PhTail1;
        push_event(EvPayload, b, 16'h0000);
      end
      PhTail1: begin
        st_tail_ok = (b == TailFirst);
        st_phase   = PhTail2;
      end
      PhTail2: begin
        st_phase = PhHunt;
        if (st_tail_ok && b == TailSecond) push_event(EvAccept, 8'h00, st_decl_len);
        else push_event(EvBadTail, 8'h00, st_decl_len);
      end
      default: begin
        if (b == SyncFirst) st_phase = PhSawAa;
        else st_phase = PhHunt;
      end
    endcase
  endfunction

  // Receiver: random stall, or a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request) begin
      out_stall_i <= 1'b1;
      hold_count++;
      if (hold_count == HoldCycles) begin
        hold_count   = 0;
        hold_request = 1'b0;
      end
    end else begin
      out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected beat: event_kind %0d, payload_byte %0h, frame_length %0d",
               event_kind_o, payload_byte_o, frame_length_o);
        errors++;
      end else begin
        head_event = pending_events.pop_front();
        if (event_kind_o !== head_event.kind) begin
          $error("event_kind: expected %0d, got %0d", head_event.kind, event_kind_o);
          errors++;
        end
        if (payload_byte_o !== head_event.data) begin
          $error("payload_byte: expected %0h, got %0h", head_event.data, payload_byte_o);
          errors++;
        end
        if (frame_length_o !== head_event.length) begin
          $error("frame_length: expected %0d, got %0d", head_event.length, frame_length_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("length_prefixed_frame_deframer test failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    st_max_len = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input int unsigned len);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    repeat (len) send_byte(8'($urandom));
    send_byte(TailFirst);
    send_byte(TailSecond);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned cap;
    int unsigned len;
    logic [15:0] flen;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(4, 1))
        send_byte(($urandom_range(3) == 0) ? SyncFirst : 8'($urandom));
      return;
    end
    if (pick < 14) send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    if (pick >= 14 && pick < 26 && st_max_len != 16'hFFFF) begin
      case ($urandom_range(3))
        0:       flen = 16'hAABB;
        1:       flen = {8'($urandom), SyncFirst};
        default: flen = 16'($urandom_range(32'hFFFF, st_max_len + 1));
      endcase
      if (flen <= st_max_len) flen = 16'hFFFF;
      send_byte(flen[15:8]);
      send_byte(flen[7:0]);
      return;
    end
    cap = ($urandom_range(15) == 0) ? 48 : 8;
    if (cap > st_max_len) cap = st_max_len;
    len = $urandom_range(cap);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    repeat (len) send_byte(8'($urandom));
    pick = $urandom_range(19);
    send_byte((pick == 0 || pick == 2) ? 8'($urandom) : TailFirst);
    send_byte((pick == 1 || pick == 2) ? 8'($urandom) : TailSecond);
  endtask

  task automatic test_directed_frames();
    // repeated sync, empty payload, bad second tail, oversize resync on AA BB, bad first tail
    send_bytes('{8'h00, SyncFirst, SyncFirst, SyncSecond, 8'h00, 8'h00, TailFirst, TailSecond,
                 SyncFirst, SyncSecond, 8'h00, 8'h01, 8'hFF, TailFirst, 8'h00,
                 SyncFirst, SyncSecond, SyncFirst, SyncSecond, 8'h00, 8'h00, 8'h00, TailSecond,
                 SyncFirst, 8'h12});
  endtask

  task automatic test_length_limits();
    write_max_length(16'd0);
    send_bytes('{SyncFirst, SyncSecond, 8'h00, 8'h00, TailFirst, TailSecond,
                 SyncFirst, SyncSecond, 8'hFF, 8'hFF, SyncFirst, SyncSecond, 8'h00, SyncFirst});
    write_max_length(16'd1);
    send_bytes('{SyncSecond, 8'h00, 8'h01, 8'h5A, TailFirst, TailSecond,
                 SyncFirst, SyncSecond, 8'h00, 8'h02});
    write_max_length(16'hFFFF);
    send_frame(3);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (4) send_frame(12);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [15:0] max_a, input logic [15:0] max_b);
    int unsigned target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_max_length(max_a);
    target = bytes_sent + RandomBytes / 2;
    while (bytes_sent < target) send_random_frame();
    write_max_length(max_b);
    target = bytes_sent + RandomBytes / 2;
    while (bytes_sent < target) send_random_frame();
  endtask

  initial begin
    st_phase    = PhHunt;
    st_len_hi   = 8'h00;
    st_decl_len = 16'h0000;
    st_left     = 16'h0000;
    st_tail_ok  = 1'b0;
    st_max_len  = MaxLenDefault;
    tx_idle_pct = 12;
    rx_idle_pct = 76;
    errors      = 0;
    bytes_sent  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_backpressure();
    test_length_limits();
    test_random_traffic(12, 76, 16'($urandom_range(20)), 16'hFFFF);
    test_random_traffic(76, 12, 16'd0, 16'($urandom_range(60)));
    test_random_traffic(0, 0, MaxLenDefault, 16'($urandom));

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("length_prefixed_frame_deframer test passed");
    end else begin
      $display("length_prefixed_frame_deframer test failed");
    end
    $finish;
  end
endmodule
